// ===== rtl/aes_ctr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES CTR package
// Shared constants, the S-box and the GF(2^8) helpers of the cipher.
// ----------------------------------------------------------------------------
package aes_ctr_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE           = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COUNTER = 2'd3;

    localparam logic [7:0] GF_POLY = 8'h1b;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [0:255];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // Byte b of the state sits at bits [127-8b -: 8], column b/4, row b%4.
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(r + 4*c) -: 8] = sbox(s[127 - 8*(r + 4*((c + r) % 4)) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32*c -: 8];
            a1 = s[119 - 32*c -: 8];
            a2 = s[111 - 32*c -: 8];
            a3 = s[103 - 32*c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    // One key-schedule step: next round key from the previous one.
    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [7:0]   rcon);
        logic [31:0] w0, w1, w2, w3, t;
        t  = sub_word({k[23:0], k[31:24]}) ^ {rcon, 24'h0};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [7:0] rcon(input int rnd);
        logic [7:0] r;
        r = 8'h01;
        for (int i = 1; i < NUM_ROUNDS; i++) begin
            if (i < rnd) begin
                r = xtime(r);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/aes_ctr_round_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES CTR round cell
// One cipher round plus one key-schedule step, registered, with a stall.
// ----------------------------------------------------------------------------
module aes_ctr_round_cell #(
    parameter int ROUND = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_advance,
    input  logic         i_valid,
    input  logic [127:0] i_state,
    input  logic [127:0] i_key,
    input  logic [127:0] i_data,
    input  logic         i_last,
    output logic         o_valid,
    output logic [127:0] o_state,
    output logic [127:0] o_key,
    output logic [127:0] o_data,
    output logic         o_last
);

    logic [127:0] n_key;
    logic [127:0] n_state;
    logic [127:0] w_sub;

    always_comb begin
        n_key = aes_ctr_pkg::next_round_key(i_key, aes_ctr_pkg::rcon(ROUND));
        w_sub = aes_ctr_pkg::sub_shift(i_state);
        if (ROUND == aes_ctr_pkg::NUM_ROUNDS) begin
            n_state = w_sub ^ n_key;
        end else begin
            n_state = aes_ctr_pkg::mix_columns(w_sub) ^ n_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_advance) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            o_state <= n_state;
            o_key   <= n_key;
            o_data  <= i_data;
            o_last  <= i_last;
        end
    end

endmodule

// ===== rtl/aes128_ctr_stream_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 CTR stream cipher
// Counter-mode AES-128 with a fully unrolled chain of ten round cells.
// ----------------------------------------------------------------------------
// One request of 128 data bits is accepted every clock cycle while the output
// side takes results. Each request builds its counter block (nonce followed by
// initial_counter + block index) and the original key, whitens it with the
// key and hands it into a chain of ten round cells. Every cell applies one
// AES round and derives its own round key from the key it received, so the
// key travels with the data and no round-key memory is needed. A request is
// registered in the entry stage and then in each round cell; the chain moves
// as one and holds when the output is stalled, so the rate is one block per
// cycle, limited only by the single round in each cell. The block index
// restarts at zero after reset, after any configuration write and after a
// request marked last. Configuration must be written while idle; not enforced.
// ----------------------------------------------------------------------------
module aes128_ctr_stream_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_data_high,
    input  logic [63:0] i_data_low,
    input  logic        i_last_in_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low,
    output logic        o_result_last
);

    localparam int NR = aes_ctr_pkg::NUM_ROUNDS;

    logic [63:0] r_key_high, r_key_low, r_nonce, r_init_ctr, r_index;

    // Entry stage registers.
    logic         r_valid0;
    logic [127:0] r_state0;
    logic [127:0] r_key0;
    logic [127:0] r_data0;
    logic         r_last0;

    logic         w_valid [0:NR];
    logic [127:0] w_state [0:NR];
    logic [127:0] w_key   [0:NR];
    logic [127:0] w_data  [0:NR];
    logic         w_last  [0:NR];
    logic         w_adv;
    logic         w_acc;
    logic [127:0] w_ctr;

    // The chain advances when the output slot is empty or being taken.
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;
    assign w_acc   = i_valid && w_adv;
    assign w_ctr   = {r_nonce, r_init_ctr + r_index};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_nonce    <= '0;
            r_init_ctr <= '0;
            r_index    <= '0;
        end else if (i_cfg_we) begin
            r_index <= '0;
            case (i_cfg_idx)
                aes_ctr_pkg::CFG_KEY_HIGH:        r_key_high <= i_cfg_data;
                aes_ctr_pkg::CFG_KEY_LOW:         r_key_low  <= i_cfg_data;
                aes_ctr_pkg::CFG_NONCE:           r_nonce    <= i_cfg_data;
                aes_ctr_pkg::CFG_INITIAL_COUNTER: r_init_ctr <= i_cfg_data;
                default:                          r_index    <= r_index;
            endcase
        end else if (w_acc) begin
            r_index <= i_last_in_message ? 64'd0 : r_index + 64'd1;
        end
    end

    // Entry stage: initial AddRoundKey.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (w_adv) begin
            r_valid0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_state0 <= w_ctr ^ {r_key_high, r_key_low};
            r_key0   <= {r_key_high, r_key_low};
            r_data0  <= {i_data_high, i_data_low};
            r_last0  <= i_last_in_message;
        end
    end

    assign w_valid[0] = r_valid0;
    assign w_state[0] = r_state0;
    assign w_key[0]   = r_key0;
    assign w_data[0]  = r_data0;
    assign w_last[0]  = r_last0;

    for (genvar g = 1; g <= NR; g++) begin : g_round
        aes_ctr_round_cell #(.ROUND(g)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_advance(w_adv),
            .i_valid  (w_valid[g-1]),
            .i_state  (w_state[g-1]),
            .i_key    (w_key[g-1]),
            .i_data   (w_data[g-1]),
            .i_last   (w_last[g-1]),
            .o_valid  (w_valid[g]),
            .o_state  (w_state[g]),
            .o_key    (w_key[g]),
            .o_data   (w_data[g]),
            .o_last   (w_last[g])
        );
    end

    assign o_valid       = w_valid[NR];
    assign o_result_high = w_data[NR][127:64] ^ w_state[NR][127:64];
    assign o_result_low  = w_data[NR][63:0] ^ w_state[NR][63:0];
    assign o_result_last = w_last[NR];

endmodule
